### hw/rtl/rne_pkg.sv
`timescale 1ns / 1ps

package rne_pkg;

   // Largest value that has a numeral
   localparam int unsigned MAX_VALUE = 3999;

   // Widths of the letter buffer carried down the pipeline
   localparam int unsigned LTR_W     = 3;
   localparam int unsigned SLOTS     = 16;
   localparam int unsigned BUF_W     = LTR_W * SLOTS;
   localparam int unsigned CNT_W     = 4;
   localparam int unsigned PAT_SLOTS = 4;
   localparam int unsigned PAT_W     = LTR_W * PAT_SLOTS;
   localparam int unsigned LEN_W     = 3;

   // Internal letter codes; LTR_NONE stands for the error result
   typedef enum logic [LTR_W-1:0] {
      LTR_NONE,
      LTR_I,
      LTR_V,
      LTR_X,
      LTR_L,
      LTR_C,
      LTR_D,
      LTR_M
   } ltr_type;

   // Pattern of one digit: slot 0 in the low bits
   typedef struct packed {
      logic [PAT_W-1:0] codes;
      logic [LEN_W-1:0] len;
   } pat_type;

   // A whole numeral handed to the output stage
   typedef struct packed {
      logic [BUF_W-1:0] codes;
      logic [CNT_W-1:0] cnt;
      logic             err;
   } num_type;

   // ASCII code of a letter
   function automatic logic [6:0] ltr_ascii(input ltr_type code);
      logic [6:0] a;
      case (code)
         LTR_I:   a = 7'h49;
         LTR_V:   a = 7'h56;
         LTR_X:   a = 7'h58;
         LTR_L:   a = 7'h4C;
         LTR_C:   a = 7'h43;
         LTR_D:   a = 7'h44;
         LTR_M:   a = 7'h4D;
         default: a = 7'h00;
      endcase
      return a;
   endfunction

   // Letters for one decimal digit, given its one, five and ten letters
   function automatic pat_type digit_pat(input logic [3:0] d, input ltr_type one,
                                         input ltr_type five, input ltr_type ten);
      pat_type p;
      p.codes = '0;
      p.len   = '0;
      case (d)
         4'd1: begin
            p.codes[2:0] = one;
            p.len = 3'd1;
         end
         4'd2: begin
            p.codes[5:0] = {one, one};
            p.len = 3'd2;
         end
         4'd3: begin
            p.codes[8:0] = {one, one, one};
            p.len = 3'd3;
         end
         4'd4: begin
            p.codes[5:0] = {five, one};
            p.len = 3'd2;
         end
         4'd5: begin
            p.codes[2:0] = five;
            p.len = 3'd1;
         end
         4'd6: begin
            p.codes[5:0] = {one, five};
            p.len = 3'd2;
         end
         4'd7: begin
            p.codes[8:0] = {one, one, five};
            p.len = 3'd3;
         end
         4'd8: begin
            p.codes[11:0] = {one, one, one, five};
            p.len = 3'd4;
         end
         4'd9: begin
            p.codes[5:0] = {ten, one};
            p.len = 3'd2;
         end
         default: begin
            p.codes = '0;
            p.len   = '0;
         end
      endcase
      return p;
   endfunction

endpackage

### hw/rtl/rne_emitter.sv
`timescale 1ns / 1ps

module rne_emitter
   import rne_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load_valid,
   input  num_type    load_num,
   output logic       load_take,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_letter,
   output logic       rsp_last,
   output logic       rsp_error
);

   logic             valid_ff;
   logic [BUF_W-1:0] codes_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             err_ff;
   logic             sent;
   logic             final_sent;

   assign sent       = valid_ff && !rsp_stall;
   assign final_sent = sent && (cnt_ff == CNT_W'(1));
   // Free for a new numeral when empty or when the last letter leaves now
   assign load_take  = !valid_ff || final_sent;

   // Control: valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_take) begin
         valid_ff <= load_valid;
      end
   end

   // Letter buffer: load a numeral, or shift out one letter per transaction
   always_ff @(posedge clock) begin
      if (load_take && load_valid) begin
         codes_ff <= load_num.codes;
         cnt_ff   <= load_num.cnt;
         err_ff   <= load_num.err;
      end else if (sent) begin
         codes_ff <= codes_ff >> LTR_W;
         cnt_ff   <= cnt_ff - CNT_W'(1);
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_letter = ltr_ascii(ltr_type'(codes_ff[LTR_W-1:0]));
   assign rsp_last   = (cnt_ff == CNT_W'(1));
   assign rsp_error  = err_ff;

endmodule

### hw/rtl/roman_numeral_encoder_top.sv
`timescale 1ns / 1ps

// Channel  | Direction | Ports                                   | Transaction
// req      | in        | req_valid, req_stall, req_value[11:0]   | one integer
// rsp      | out       | rsp_valid, rsp_stall, rsp_letter[6:0],  | one letter
//          |           | rsp_last, rsp_error                     |
//
// Four register stages (thousands, hundreds, tens/units with patterns, merge) feed an
// output stage, which registers each numeral before rsp_valid rises for it.
// The output stage sends one letter per cycle while rsp_stall is low: a numeral has
// 1 to 15 letters, an error result has one; an input of 0 sends nothing on rsp.
// reset is synchronous and clears only the valid bits of the stages.
// rsp_stall holds the output stage and backs up through the stages to req_stall;
// req accepts one transaction per cycle while any stage has room.

module roman_numeral_encoder_top
   import rne_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_letter,
   output logic        rsp_last,
   output logic        rsp_error
);

   // Stage registers
   logic         s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic [1:0]   s1_th_ff, s2_th_ff;
   logic [9:0]   s1_rem_ff;
   logic [3:0]   s2_hu_ff;
   logic [6:0]   s2_rem_ff;
   logic         s1_err_ff, s2_err_ff, s3_err_ff;
   pat_type      s3_pat_ff [PAT_SLOTS];
   num_type      s4_num_ff;

   // Next values
   logic [1:0]   s1_th_in;
   logic [9:0]   s1_rem_in;
   logic         s1_err_in;
   logic [3:0]   s2_hu_in;
   logic [6:0]   s2_rem_in;
   logic [3:0]   s3_te;
   logic [3:0]   s3_un;
   pat_type      s3_pat_in [PAT_SLOTS];
   num_type      s4_num_in;

   logic         en1, en2, en3, en4;
   logic         load_take;
   logic         pop4;

   // Flow control: a stage moves when it is empty or its successor moves
   assign pop4      = s4_v_ff && ((s4_num_ff.cnt == '0) || load_take);
   assign en4       = !s4_v_ff || pop4;
   assign en3       = !s3_v_ff || en4;
   assign en2       = !s2_v_ff || en3;
   assign en1       = !s1_v_ff || en2;
   assign req_stall = !en1;

   // Stage 1: range check and thousands digit
   always_comb begin
      s1_err_in = (req_value > 12'(MAX_VALUE));
      s1_th_in  = '0;
      s1_rem_in = req_value[9:0];
      for (int k = 1; k <= 3; k++) begin
         if (req_value >= 12'(k * 1000)) begin
            s1_th_in  = 2'(k);
            s1_rem_in = 10'(req_value - 12'(k * 1000));
         end
      end
   end

   // Stage 2: hundreds digit
   always_comb begin
      s2_hu_in  = '0;
      s2_rem_in = s1_rem_ff[6:0];
      for (int k = 1; k <= 9; k++) begin
         if (s1_rem_ff >= 10'(k * 100)) begin
            s2_hu_in  = 4'(k);
            s2_rem_in = 7'(s1_rem_ff - 10'(k * 100));
         end
      end
   end

   // Stage 3: tens and units, then the pattern of each digit
   always_comb begin
      s3_te = '0;
      s3_un = s2_rem_ff[3:0];
      for (int k = 1; k <= 9; k++) begin
         if (s2_rem_ff >= 7'(k * 10)) begin
            s3_te = 4'(k);
            s3_un = 4'(s2_rem_ff - 7'(k * 10));
         end
      end
      s3_pat_in[0] = digit_pat({2'b00, s2_th_ff}, LTR_M, LTR_M, LTR_M);
      s3_pat_in[1] = digit_pat(s2_hu_ff, LTR_C, LTR_D, LTR_M);
      s3_pat_in[2] = digit_pat(s3_te, LTR_X, LTR_L, LTR_C);
      s3_pat_in[3] = digit_pat(s3_un, LTR_I, LTR_V, LTR_X);
   end

   // Stage 4: pack the four patterns into one letter buffer, or one error letter on a range error
   always_comb begin
      logic [BUF_W-1:0] codes;
      logic [CNT_W-1:0] off;
      codes = '0;
      off   = '0;
      for (int p = 0; p < PAT_SLOTS; p++) begin
         codes = codes | (BUF_W'(s3_pat_ff[p].codes) << (6'(off) * 6'd3));
         off   = off + CNT_W'(s3_pat_ff[p].len);
      end
      if (s3_err_ff) begin
         s4_num_in.codes = BUF_W'(LTR_NONE);
         s4_num_in.cnt   = CNT_W'(1);
         s4_num_in.err   = 1'b1;
      end else begin
         s4_num_in.codes = codes;
         s4_num_in.cnt   = off;
         s4_num_in.err   = 1'b0;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (en1) s1_v_ff <= req_valid;
         if (en2) s2_v_ff <= s1_v_ff;
         if (en3) s3_v_ff <= s2_v_ff;
         if (en4) s4_v_ff <= s3_v_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_th_ff  <= s1_th_in;
         s1_rem_ff <= s1_rem_in;
         s1_err_ff <= s1_err_in;
      end
      if (en2) begin
         s2_th_ff  <= s1_th_ff;
         s2_hu_ff  <= s2_hu_in;
         s2_rem_ff <= s2_rem_in;
         s2_err_ff <= s1_err_ff;
      end
      if (en3) begin
         s3_pat_ff <= s3_pat_in;
         s3_err_ff <= s2_err_ff;
      end
      if (en4) begin
         s4_num_ff <= s4_num_in;
      end
   end

   // Output stage: letters of numerals with no letters are never loaded
   rne_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s4_v_ff && (s4_num_ff.cnt != '0)),
      .load_num   (s4_num_ff),
      .load_take  (load_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_letter (rsp_letter),
      .rsp_last   (rsp_last),
      .rsp_error  (rsp_error)
   );

endmodule

### hw/rtl/rne_checker.sv
`timescale 1ns / 1ps

module rne_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [6:0] rsp_letter,
   input logic       rsp_last,
   input logic       rsp_error
);

   // Reset empties the output
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // An error transaction is a lone result with letter 0
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && (rsp_letter == 7'h00))
      else $error("malformed error transaction");

   // Normal letters are Roman letters
   a_letter_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error |->
         (rsp_letter == 7'h49) || (rsp_letter == 7'h56) || (rsp_letter == 7'h58) ||
         (rsp_letter == 7'h4C) || (rsp_letter == 7'h43) || (rsp_letter == 7'h44) ||
         (rsp_letter == 7'h4D))
      else $error("letter outside I V X L C D M");

   // A numeral goes out without gaps
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid && !rsp_error)
      else $error("gap inside a numeral");

   // Stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_letter) && $stable(rsp_last)
         && $stable(rsp_error))
      else $error("stalled result changed");

endmodule

bind roman_numeral_encoder_top rne_checker u_rne_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_letter (rsp_letter),
   .rsp_last   (rsp_last),
   .rsp_error  (rsp_error)
);

### verif/numeral_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the encoder, works out the letters each accepted
// integer should produce and compares them in order with what comes out.
module numeral_checker
   import rne_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [11:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [6:0]  rsp_letter,
   input  logic        rsp_last,
   input  logic        rsp_error,
   output int          mismatches,
   output int          outstanding
);

   // ASCII codes of the letters; the error result carries NUL
   localparam logic [6:0] CH_NONE = 7'h00;
   localparam logic [6:0] CH_I    = 7'h49;
   localparam logic [6:0] CH_V    = 7'h56;
   localparam logic [6:0] CH_X    = 7'h58;
   localparam logic [6:0] CH_L    = 7'h4C;
   localparam logic [6:0] CH_C    = 7'h43;
   localparam logic [6:0] CH_D    = 7'h44;
   localparam logic [6:0] CH_M    = 7'h4D;

   typedef struct packed {
      logic [6:0] letter;
      logic       last;
      logic       error;
   } letter_item_type;

   letter_item_type expected_letters[$];
   int              fail_count = 0;

   // Append the letters of one integer to the expected stream
   function automatic void predict_numeral(input logic [11:0] v);
      logic [6:0]      seq[$];
      logic [6:0]      one;
      logic [6:0]      five;
      logic [6:0]      ten;
      int unsigned     scale;
      int unsigned     d;
      letter_item_type item;
      if (v > MAX_VALUE) begin
         item.letter = CH_NONE;
         item.last   = 1'b1;
         item.error  = 1'b1;
         expected_letters.push_back(item);
         return;
      end
      scale = 1000;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               one = CH_M; five = CH_M; ten = CH_M;
            end
            1: begin
               one = CH_C; five = CH_D; ten = CH_M;
            end
            2: begin
               one = CH_X; five = CH_L; ten = CH_C;
            end
            default: begin
               one = CH_I; five = CH_V; ten = CH_X;
            end
         endcase
         d = (int'(v) / scale) % 10;
         if (d == 9) begin
            seq.push_back(one);
            seq.push_back(ten);
         end else if (d == 4) begin
            seq.push_back(one);
            seq.push_back(five);
         end else begin
            if (d >= 5) begin
               seq.push_back(five);
               d = d - 5;
            end
            for (int k = 0; k < d; k++) seq.push_back(one);
         end
         scale = scale / 10;
      end
      foreach (seq[k]) begin
         item.letter = seq[k];
         item.last   = (k == seq.size() - 1);
         item.error  = 1'b0;
         expected_letters.push_back(item);
      end
   endfunction

   // Compare each delivered letter with the oldest one predicted
   always @(posedge clock) begin
      letter_item_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_letters.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected letter %h last %b error %b", $realtime,
                           rsp_letter, rsp_last, rsp_error);
            end else begin
               want = expected_letters.pop_front();
               if (rsp_letter !== want.letter || rsp_last !== want.last ||
                   rsp_error !== want.error) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: expected letter %h last %b error %b, got %h %b %b",
                              $realtime, want.letter, want.last, want.error,
                              rsp_letter, rsp_last, rsp_error);
               end
            end
         end
         if (req_valid && !req_stall) predict_numeral(req_value);
      end
      mismatches  <= fail_count;
      outstanding <= expected_letters.size();
   end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int IDLE_LIMIT = 2000;
   localparam int LONG_HOLD  = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [11:0] req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [6:0]  rsp_letter;
   logic        rsp_last;
   logic        rsp_error;
   int          mismatches;
   int          outstanding;
   int          idle_cycles;
   bit          req_quiet;
   bit          rsp_quiet;

   // zero, unit digits 1, 4, 5, 8 and 9, subtractive pairs, limits and overflow
   int          directed [24] = '{0, 1, 4, 5, 9, 10, 40, 49, 90, 99, 400, 444, 500, 900,
                                  999, 1000, 3000, 3888, 3999, 4000, 4095, 2048, 1994,
                                  3444};

   roman_numeral_encoder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_letter (rsp_letter),
      .rsp_last   (rsp_last),
      .rsp_error  (rsp_error)
   );

   numeral_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_letter  (rsp_letter),
      .rsp_last    (rsp_last),
      .rsp_error   (rsp_error),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one integer after a random gap (none while req_quiet is set) and hold it until taken
   task automatic send_value(input logic [11:0] v);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Digit that makes a long pattern
   function automatic int long_digit();
      int pick;
      pick = $urandom_range(0, 2);
      return (pick == 0) ? 3 : (pick == 1) ? 7 : 8;
   endfunction

   // Stimulus: directed corner values, then random integers
   initial begin
      int r;
      int v;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      req_quiet = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) send_value(12'(directed[i]));

      for (int i = 0; i < 400; i++) begin
         if (i % 50 == 0) req_quiet = ($urandom_range(0, 2) == 0);
         r = $urandom_range(0, 99);
         if (r < 75) v = $urandom_range(1, 3999);
         else if (r < 85)
            v = $urandom_range(0, 3) * 1000 + long_digit() * 100 + long_digit() * 10
                + long_digit();
         else if (r < 93) v = $urandom_range(4000, 4095);
         else if (r < 96) v = 0;
         else v = $urandom_range(0, 4095);
         send_value(12'(v));
      end
      req_valid <= 1'b0;

      // drain, then wait for stray letters
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("roman_numeral_encoder_top: match");
      end else begin
         $display("roman_numeral_encoder_top: mismatch");
      end
      $finish;
   end

   // Receiver: random stalls, quiet stretches and two long holds
   initial begin
      int got;
      int waits;
      got       = 0;
      rsp_stall = 1'b0;
      rsp_quiet = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (got == 40 || got == 1200) waits = LONG_HOLD;
         else if (rsp_quiet) waits = 0;
         else waits = $urandom_range(0, 3);
         if (waits > 0) begin
            rsp_stall <= 1'b1;
            repeat (waits) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got++;
         if (got % 64 == 0) rsp_quiet = ($urandom_range(0, 2) == 0);
         @(negedge clock);
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("roman_numeral_encoder_top: mismatch");
            $finish;
         end
      end
   end

endmodule
